FILE: hw/rtl/elu_activation_macros.svh
// Assertion helpers for the ELU block. Each expects clk and rst in scope.
`ifndef ELU_ACTIVATION_MACROS_SVH
`define ELU_ACTIVATION_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ELU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define ELU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/elu_pkg.sv
package elu_pkg;

  localparam int LUT_ENTRIES = 256;
  localparam int DATA_WIDTH  = 16;
  localparam int FRAC_BITS   = 12;

  // Interpolation weight bits; the table spans 2^WGT_BITS input codes.
  localparam int WGT_BITS    = 15;
  localparam int SPAN_Q12    = 1 << WGT_BITS;
  localparam int IDX_W       = $clog2(LUT_ENTRIES);
  // Table points lie in [-1.0, 0] in Q.12.
  localparam int ROM_W       = FRAC_BITS + 1;
  localparam int ALPHA_W     = 15;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(1 << FRAC_BITS);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x_value;
    logic                         last_in;
  } elu_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] y_value;
    logic                         last_out;
  } elu_out_t;

  typedef logic signed [ROM_W-1:0] lut_t [LUT_ENTRIES];

  // Truncating unsigned quotient by shift and subtract; used only while the
  // constant table is built.
  function automatic longint unsigned const_udiv(longint unsigned num,
                                                 longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int bit_pos = 63; bit_pos >= 0; bit_pos--) begin
      rem = {rem[62:0], num[bit_pos]};
      if (rem >= den) begin
        rem          = rem - den;
        quo[bit_pos] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-k/N)^8 - 1 in Q.12, with k = N - i. Taylor series in Q40,
  // rounded to Q31, squared three times, rounded to Q12.
  function automatic logic signed [ROM_W-1:0] rom_point(int unsigned i);
    longint unsigned k;
    longint unsigned term;
    longint unsigned g;
    longint          sum;
    k    = longint'(LUT_ENTRIES) - longint'(i);
    term = 64'd1 << 40;
    sum  = 64'sd1 <<< 40;
    for (int n = 1; n <= 25; n++) begin
      term = const_udiv(term * k, longint'(LUT_ENTRIES) * longint'(n));
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    g = (longint'(sum) + (64'd1 << 8)) >> 9;
    for (int s = 0; s < 3; s++) begin
      g = (g * g + (64'd1 << 30)) >> 31;
    end
    g = (g + (64'd1 << 18)) >> 19;
    return ROM_W'(longint'(g) - (64'sd1 <<< FRAC_BITS));
  endfunction

  // Table of points offset..offset+N-1; offset 1 gives the upper neighbor.
  function automatic lut_t build_lut(int unsigned offset);
    lut_t t;
    for (int i = 0; i < LUT_ENTRIES; i++) begin
      t[i] = rom_point(i + offset);
    end
    return t;
  endfunction

endpackage

FILE: hw/rtl/elu_activation.sv
// ELU activation over a stream of signed Q.12 elements: y = x for x >= 0 and
// y = alpha * (exp(x) - 1) for x < 0, rounded half away from zero and
// saturated to the most negative code. exp(x) - 1 comes from a constant
// table of LUT_ENTRIES segments over [-8, 0] with linear interpolation;
// inputs below -8 take the table's first point. alpha is unsigned Q3.12
// (reset 1.0); the user must write it through cfg_write/cfg_data only while
// the stream is idle, which the block does not enforce. The datapath is a
// four-stage pipeline (index, table read, interpolate, scale) in registers
// s1 to s4; one beat enters per clock while the output is not stalled. Each
// stage holds only while its successor is full and stalled, so bubbles
// collapse under backpressure; last_in rides with its element to last_out.
`include "elu_activation_macros.svh"

module elu_activation
  import elu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  elu_in_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output elu_out_t           out_data,
  input  logic               cfg_write,
  input  logic [ALPHA_W-1:0] cfg_data
);

  localparam int XW   = (DATA_WIDTH > 16 ? DATA_WIDTH : 16) + 1;
  localparam int PW   = WGT_BITS + IDX_W;
  localparam int QW   = ALPHA_W + ROM_W + 1 - FRAC_BITS;
  localparam int YW   = (DATA_WIDTH > QW ? DATA_WIDTH : QW) + 1;
  localparam lut_t LO_LUT = build_lut(0);
  localparam lut_t HI_LUT = build_lut(1);

  logic [ALPHA_W-1:0] alpha;

  // Stage registers.
  logic                         s1_valid, s2_valid, s3_valid, s4_valid;
  logic signed [DATA_WIDTH-1:0] s1_x, s2_x, s3_x;
  logic                         s1_last, s2_last, s3_last;
  logic                         s1_neg, s2_neg, s3_neg, s4_neg;
  logic [IDX_W-1:0]             s1_idx;
  logic [WGT_BITS-1:0]          s1_wgt, s2_wgt;
  logic signed [ROM_W-1:0]      s2_lo;
  logic [ROM_W-1:0]             s2_diff;
  logic [ROM_W-1:0]             s3_mag;
  elu_out_t                     s4_data;

  logic s1_en, s2_en, s3_en, s4_en;

  // Advance a stage whenever it is empty or its successor moves.
  assign s4_en    = !s4_valid || out_ready;
  assign s3_en    = !s3_valid || s4_en;
  assign s2_en    = !s2_valid || s3_en;
  assign s1_en    = !s1_valid || s2_en;
  assign in_ready = s1_en;

  assign out_valid = s4_valid;
  assign out_data  = s4_data;

  // Stage 1: offset x into the table span, split into index and weight.
  logic signed [XW-1:0] x_ext, x_off;
  logic [PW-1:0]        pos;
  logic                 below;
  logic [IDX_W-1:0]     idx_next;
  logic [WGT_BITS-1:0]  wgt_next;

  always_comb begin
    x_ext = XW'(in_data.x_value);
    x_off = x_ext + XW'(SPAN_Q12);
    below = x_off[XW-1];
    pos   = PW'(x_off[WGT_BITS-1:0]) * PW'(LUT_ENTRIES);
    if (below) begin
      // Clamp below -8 onto the first table point.
      idx_next = '0;
      wgt_next = '0;
    end else begin
      idx_next = pos[PW-1:WGT_BITS];
      wgt_next = pos[WGT_BITS-1:0];
    end
  end

  // Stage 2: read both neighbors, drop any negative slope.
  logic signed [ROM_W-1:0] lo_pt, hi_pt;
  logic signed [ROM_W:0]   slope;
  logic [ROM_W-1:0]        diff_next;

  always_comb begin
    lo_pt = LO_LUT[s1_idx];
    hi_pt = HI_LUT[s1_idx];
    slope = (ROM_W + 1)'(hi_pt) - (ROM_W + 1)'(lo_pt);
    if (slope[ROM_W]) begin
      diff_next = '0;
    end else begin
      diff_next = slope[ROM_W-1:0];
    end
  end

  // Stage 3: interpolate and take the magnitude of exp(x) - 1.
  logic [ROM_W+WGT_BITS-1:0] frac_prod;
  logic [ROM_W-1:0]          frac;
  logic signed [ROM_W+1:0]   e_val;
  logic [ROM_W-1:0]          mag_next;

  always_comb begin
    frac_prod = (ROM_W + WGT_BITS)'(s2_diff) * (ROM_W + WGT_BITS)'(s2_wgt)
              + (ROM_W + WGT_BITS)'(1 << (WGT_BITS - 1));
    frac      = frac_prod[ROM_W+WGT_BITS-1:WGT_BITS];
    e_val     = (ROM_W + 2)'(s2_lo) + (ROM_W + 2)'({1'b0, frac});
    if (!e_val[ROM_W+1]) begin
      mag_next = '0;
    end else begin
      mag_next = ROM_W'(-e_val);
    end
  end

  // Stage 4: scale by alpha, round, negate, saturate; pick the branch.
  logic [ALPHA_W+ROM_W:0]         scaled;
  logic [YW-1:0]                  q_ext;
  logic signed [DATA_WIDTH-1:0]   y_neg;
  elu_out_t                       data_next;

  always_comb begin
    scaled = (ALPHA_W + ROM_W + 1)'(alpha) * (ALPHA_W + ROM_W + 1)'(s3_mag)
           + (ALPHA_W + ROM_W + 1)'(1 << (FRAC_BITS - 1));
    q_ext  = YW'(scaled[ALPHA_W+ROM_W:FRAC_BITS]);
    if (q_ext > (YW'(1) << (DATA_WIDTH - 1))) begin
      y_neg = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
    end else begin
      y_neg = DATA_WIDTH'(-q_ext);
    end
    data_next.last_out = s3_last;
    data_next.y_value  = s3_neg ? y_neg : s3_x;
  end

  // Control state: valid bits and the alpha register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      alpha    <= ALPHA_RESET;
    end else begin
      if (s1_en) begin
        s1_valid <= in_valid;
      end
      if (s2_en) begin
        s2_valid <= s1_valid;
      end
      if (s3_en) begin
        s3_valid <= s2_valid;
      end
      if (s4_en) begin
        s4_valid <= s3_valid;
      end
      if (cfg_write) begin
        alpha <= cfg_data;
      end
    end
  end

  // Payload: load only on a live beat, hold while stalled.
  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_x    <= in_data.x_value;
      s1_last <= in_data.last_in;
      s1_neg  <= in_data.x_value[DATA_WIDTH-1];
      s1_idx  <= idx_next;
      s1_wgt  <= wgt_next;
    end
    if (s2_en && s1_valid) begin
      s2_x    <= s1_x;
      s2_last <= s1_last;
      s2_neg  <= s1_neg;
      s2_wgt  <= s1_wgt;
      s2_lo   <= lo_pt;
      s2_diff <= diff_next;
    end
    if (s3_en && s2_valid) begin
      s3_x    <= s2_x;
      s3_last <= s2_last;
      s3_neg  <= s2_neg;
      s3_mag  <= mag_next;
    end
    if (s4_en && s3_valid) begin
      s4_neg  <= s3_neg;
      s4_data <= data_next;
    end
  end

  // The interpolated magnitude never exceeds 1.0.
  `ELU_ASSERT_NOW(a_mag_range, s3_valid, s3_mag <= ROM_W'(1 << FRAC_BITS), "magnitude above 1.0")
  // Non-negative inputs leave non-negative; negative inputs leave non-positive.
  `ELU_ASSERT_NOW(a_sign_kept, s4_valid, (s4_neg == s4_data.y_value[DATA_WIDTH-1]) || (s4_neg && (s4_data.y_value == '0)), "result sign does not match branch")
  // A full pipeline facing a stalled output must refuse input.
  `ELU_ASSERT_NOW(a_full_stall, s1_valid && s2_valid && s3_valid && s4_valid && !out_ready, !in_ready, "input taken into a full stalled pipeline")
  // An accepted beat lands in the first stage.
  `ELU_ASSERT_NEXT(a_enter, in_valid && in_ready, s1_valid, "accepted beat lost at entry")

endmodule
